[rtl/drtt_pkg.sv]
package drtt_pkg;

    localparam int TRIM_BITS    = 5;
    localparam int MAX_ATTEMPTS = 10;

    localparam int TRIM_FIELD_W = 5;
    localparam int WORD_W       = 10;
    localparam int MV_W         = 12;
    localparam int MON_W        = 11;
    localparam int TOL_W        = 8;
    localparam int ERR_W        = 13;
    localparam int ATT_W        = 8;
    localparam int STATUS_W     = 2;

    localparam logic [TRIM_BITS-1:0] TRIM_MAX = {TRIM_BITS{1'b1}};
    localparam logic [TRIM_BITS-1:0] TRIM_MID = TRIM_BITS'(1 << (TRIM_BITS - 1));
    localparam logic [ERR_W-1:0]     ERR_ALL  = {ERR_W{1'b1}};
    localparam logic [ATT_W-1:0]     ATT_MAX  = {ATT_W{1'b1}};
    localparam logic [ATT_W-1:0]     ATT_LIMIT = ATT_W'(MAX_ATTEMPTS);

    localparam logic [MV_W-1:0]  DIG_TARGET_RST = 12'd1300;
    localparam logic [MV_W-1:0]  ANA_TARGET_RST = 12'd1200;
    localparam logic [TOL_W-1:0] DIG_TOL_RST    = 8'd20;
    localparam logic [TOL_W-1:0] ANA_TOL_RST    = 8'd20;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DIG_TARGET = 2'd0;
    localparam logic [1:0] REG_ANA_TARGET = 2'd1;
    localparam logic [1:0] REG_DIG_TOL    = 2'd2;
    localparam logic [1:0] REG_ANA_TOL    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_WANT   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TUNED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FAILED = 2'd2;

    localparam logic OP_START   = 1'b0;
    localparam logic RAIL_DIG   = 1'b0;
    localparam logic RAIL_ANA   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DIG_INIT = 3'd1,
        PH_DIG_SCAN = 3'd2,
        PH_ANA_INIT = 3'd3,
        PH_ANA_SCAN = 3'd4,
        PH_TUNED    = 3'd5,
        PH_FAILED   = 3'd6
    } phase_t;

    typedef struct packed {
        logic [MV_W-1:0]  dig_target;
        logic [MV_W-1:0]  ana_target;
        logic [TOL_W-1:0] dig_tol;
        logic [TOL_W-1:0] ana_tol;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0]       trim_word;
        logic                    measure_rail;
        logic [STATUS_W-1:0]     status;
        logic [TRIM_FIELD_W-1:0] best_digital_trim;
        logic [TRIM_FIELD_W-1:0] best_analog_trim;
        logic [ATT_W-1:0]        attempt_count;
    } result_t;

    // Analog trim above digital trim, cut to the word width.
    function automatic logic [WORD_W-1:0] pack_trims(input logic [TRIM_BITS-1:0] ana,
                                                     input logic [TRIM_BITS-1:0] dig);
        logic [15:0] tmp;
        tmp = (16'(ana) << TRIM_BITS) | 16'(dig);
        return tmp[WORD_W-1:0];
    endfunction

    function automatic logic [TRIM_FIELD_W-1:0] trim_field(input logic [TRIM_BITS-1:0] t);
        logic [15:0] tmp;
        tmp = 16'(t);
        return tmp[TRIM_FIELD_W-1:0];
    endfunction

endpackage

[rtl/drtt_cfg.sv]
module drtt_cfg
    import drtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dig_target <= DIG_TARGET_RST;
            cfg_reg.ana_target <= ANA_TARGET_RST;
            cfg_reg.dig_tol    <= DIG_TOL_RST;
            cfg_reg.ana_tol    <= ANA_TOL_RST;
        end else if (wr_en) begin
            case (idx)
                REG_DIG_TARGET: cfg_reg.dig_target <= pwdata[MV_W-1:0];
                REG_ANA_TARGET: cfg_reg.ana_target <= pwdata[MV_W-1:0];
                REG_DIG_TOL:    cfg_reg.dig_tol    <= pwdata[TOL_W-1:0];
                REG_ANA_TOL:    cfg_reg.ana_tol    <= pwdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DIG_TARGET: prdata = 32'(cfg_reg.dig_target);
            REG_ANA_TARGET: prdata = 32'(cfg_reg.ana_target);
            REG_DIG_TOL:    prdata = 32'(cfg_reg.dig_tol);
            REG_ANA_TOL:    prdata = 32'(cfg_reg.ana_tol);
            default:        prdata = 32'd0;
        endcase
    end

endmodule

[rtl/drtt_step.sv]
module drtt_step
    import drtt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic             op,
    input  logic [MON_W-1:0] monitor_mv,
    input  cfg_t             cfg,
    output result_t          res
);

    phase_t                phase_reg, phase_next;
    logic                  scan_up_reg, scan_up_next;
    logic                  stop_up_reg, stop_up_next;
    logic [TRIM_BITS-1:0]  scan_trim_reg, scan_trim_next;
    logic [ERR_W-1:0]      best_err_reg, best_err_next;
    logic [TRIM_BITS-1:0]  best_trim_reg, best_trim_next;
    logic [TRIM_BITS-1:0]  chosen_reg, chosen_next;
    logic [MV_W-1:0]       live_dig_reg, live_dig_next;
    logic [MV_W-1:0]       live_ana_reg, live_ana_next;
    logic [ATT_W-1:0]      att_reg, att_next;

    logic                  ana;
    logic [MV_W-1:0]       reading, target, diff, lowered;
    logic [TOL_W-1:0]      tol;
    logic [TOL_W:0]        tol2;
    logic                  stop;
    logic [WORD_W-1:0]     word;
    logic                  rail;
    logic [STATUS_W-1:0]   status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            scan_up_reg   <= 1'b0;
            stop_up_reg   <= 1'b0;
            scan_trim_reg <= TRIM_MID;
            best_err_reg  <= ERR_ALL;
            best_trim_reg <= '0;
            chosen_reg    <= '0;
            live_dig_reg  <= DIG_TARGET_RST;
            live_ana_reg  <= ANA_TARGET_RST;
            att_reg       <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            scan_up_reg   <= scan_up_next;
            stop_up_reg   <= stop_up_next;
            scan_trim_reg <= scan_trim_next;
            best_err_reg  <= best_err_next;
            best_trim_reg <= best_trim_next;
            chosen_reg    <= chosen_next;
            live_dig_reg  <= live_dig_next;
            live_ana_reg  <= live_ana_next;
            att_reg       <= att_next;
        end
    end

    assign ana     = (phase_reg == PH_ANA_INIT) || (phase_reg == PH_ANA_SCAN);
    assign reading = {monitor_mv, 1'b0};
    assign target  = ana ? live_ana_reg : live_dig_reg;
    assign tol     = ana ? cfg.ana_tol : cfg.dig_tol;
    assign tol2    = {tol, 1'b0};
    assign diff    = (reading > target) ? reading - target : target - reading;
    assign lowered = (target > MV_W'(tol2)) ? target - MV_W'(tol2) : '0;

    always_comb begin
        phase_next     = phase_reg;
        scan_up_next   = scan_up_reg;
        stop_up_next   = stop_up_reg;
        scan_trim_next = scan_trim_reg;
        best_err_next  = best_err_reg;
        best_trim_next = best_trim_reg;
        chosen_next    = chosen_reg;
        live_dig_next  = live_dig_reg;
        live_ana_next  = live_ana_reg;
        att_next       = att_reg;
        word           = pack_trims(TRIM_MID, TRIM_MID);
        rail           = RAIL_DIG;
        status         = STATUS_WANT;
        stop           = 1'b0;

        if (op == OP_START) begin
            att_next       = '0;
            live_dig_next  = cfg.dig_target;
            live_ana_next  = cfg.ana_target;
            phase_next     = PH_DIG_INIT;
            scan_up_next   = 1'b0;
            stop_up_next   = 1'b0;
            scan_trim_next = TRIM_MID;
            best_err_next  = ERR_ALL;
            best_trim_next = '0;
            chosen_next    = '0;
        end else begin
            case (phase_reg)
                PH_DIG_INIT, PH_ANA_INIT: begin
                    scan_up_next   = (reading <= target);
                    stop_up_next   = (reading < target);
                    scan_trim_next = TRIM_MID;
                    best_err_next  = ERR_ALL;
                    best_trim_next = '0;
                    if (ana) begin
                        phase_next = PH_ANA_SCAN;
                        word       = pack_trims(TRIM_MID, chosen_reg);
                        rail       = RAIL_ANA;
                    end else begin
                        phase_next = PH_DIG_SCAN;
                    end
                end
                PH_DIG_SCAN, PH_ANA_SCAN: begin
                    if (ERR_W'(diff) < best_err_reg) begin
                        best_err_next  = ERR_W'(diff);
                        best_trim_next = scan_trim_reg;
                    end
                    if (stop_up_reg) begin
                        stop = ERR_W'(reading) > (ERR_W'(target) + ERR_W'(tol));
                    end else begin
                        stop = (target >= MV_W'(tol)) && (reading < target - MV_W'(tol));
                    end
                    if (scan_up_reg && (scan_trim_reg >= TRIM_MAX)) begin
                        stop = 1'b1;
                    end
                    if (!scan_up_reg && (scan_trim_reg == '0)) begin
                        stop = 1'b1;
                    end

                    if (!stop) begin
                        scan_trim_next = scan_up_reg ? scan_trim_reg + 1'b1
                                                     : scan_trim_reg - 1'b1;
                        if (ana) begin
                            word = pack_trims(scan_trim_next, chosen_reg);
                            rail = RAIL_ANA;
                        end else begin
                            word = pack_trims(TRIM_MID, scan_trim_next);
                        end
                    end else if (best_err_next > ERR_W'(tol)) begin
                        // Rail out of tolerance: lower its target and retry the chip, or fail at the attempt limit.
                        if (ana) begin
                            live_ana_next = lowered;
                        end else begin
                            live_dig_next = lowered;
                        end
                        if (att_reg < ATT_MAX) begin
                            att_next = att_reg + 1'b1;
                        end
                        scan_up_next   = 1'b0;
                        stop_up_next   = 1'b0;
                        scan_trim_next = TRIM_MID;
                        best_err_next  = ERR_ALL;
                        best_trim_next = '0;
                        chosen_next    = '0;
                        if (att_next >= ATT_LIMIT) begin
                            phase_next = PH_FAILED;
                            status     = STATUS_FAILED;
                        end else begin
                            phase_next = PH_DIG_INIT;
                        end
                    end else if (!ana) begin
                        chosen_next    = best_trim_next;
                        best_trim_next = '0;
                        best_err_next  = ERR_ALL;
                        phase_next     = PH_ANA_INIT;
                        word           = pack_trims(TRIM_MID, chosen_next);
                        rail           = RAIL_ANA;
                    end else begin
                        phase_next = PH_TUNED;
                        word       = pack_trims(best_trim_next, chosen_reg);
                        status     = STATUS_TUNED;
                    end
                end
                PH_TUNED: begin
                    word   = pack_trims(best_trim_reg, chosen_reg);
                    status = STATUS_TUNED;
                end
                PH_FAILED: begin
                    status = STATUS_FAILED;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        res.trim_word         = word;
        res.measure_rail      = rail;
        res.status            = status;
        res.best_digital_trim = trim_field(chosen_next);
        res.best_analog_trim  = ((phase_next == PH_ANA_SCAN) || (phase_next == PH_TUNED))
                                ? trim_field(best_trim_next) : '0;
        res.attempt_count     = att_next;
    end

endmodule

[rtl/dual_rail_trim_tuner.sv]
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// s_       | in        | s_tvalid / s_tready        | s_tuser operation, s_tdata monitor_mv
// m_       | out       | m_tvalid / m_tready        | m_tuser status, m_tdata trim results
// APB      | in        | psel / penable, pready = 1 | four configuration registers
//
// Every accepted input transaction yields exactly one output transaction, via the input and
// result registers. One transaction is accepted per cycle while m_tready does not stall; the
// rate is set by the single step stage, which holds the tuning state and updates it once per
// transaction. Reset (aresetn low, synchronous) empties both pipeline registers and returns
// the tuner to idle with register reset values. A stall on m_tready holds the result register
// and the input register keeps taking one more transaction before s_tready drops.
module dual_rail_trim_tuner
    import drtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [10:0] monitor_mv, [15:11] zero
    input  logic [0:0]  s_tuser,   // [0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] trim_word, [10] measure_rail, [15:11] best_digital_trim,
    // [20:16] best_analog_trim, [28:21] attempt_count, [31:29] zero
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t             cfg;
    result_t          res;

    logic             in_valid_reg;
    logic             in_op_reg;
    logic [MON_W-1:0] in_mon_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    logic             advance;

    // The step stage fires whenever an input is held and the result register can take it.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    drtt_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    drtt_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .op         (in_op_reg),
        .monitor_mv (in_mon_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg  <= s_tuser[0];
            in_mon_reg <= s_tdata[MON_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = {3'd0,
                       out_res_reg.attempt_count,
                       out_res_reg.best_analog_trim,
                       out_res_reg.best_digital_trim,
                       out_res_reg.measure_rail,
                       out_res_reg.trim_word};

endmodule
